### rtl/core/comb_pkg.sv
// Shared types and constants for the combination enumerator.
package comb_pkg;

    localparam int MAX_R       = 10;
    localparam int MAX_N       = 16;
    localparam int VALUE_WIDTH = 16;

    localparam int IDX_W       = $clog2(MAX_N);
    localparam int SLOT_IX_W   = $clog2(MAX_R);
    localparam int R_W         = 4;
    localparam int N_W         = 5;
    localparam int SLOT_W      = 4;
    localparam int LOAD_IDX_W  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Register index as decoded from paddr[2].
    localparam logic REG_COMB_SIZE = 1'b0;
    localparam logic REG_SET_SIZE  = 1'b1;

    localparam logic [R_W-1:0] COMB_SIZE_RESET = R_W'(1);
    localparam logic [N_W-1:0] SET_SIZE_RESET  = N_W'(16);

    typedef struct packed {
        logic                          req_type;
        logic [LOAD_IDX_W-1:0]         load_index;
        logic signed [VALUE_WIDTH-1:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] item_value;
        logic [SLOT_W-1:0]             item_slot;
        logic                          last_of_run;
        logic                          exhausted;
    } t_out_item;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_NEXT = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_NEXT,
        OP_EXHAUST
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op                op;
        logic [IDX_W-1:0]       addr;
        logic [VALUE_WIDTH-1:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ADVANCE,
        ST_PRIME,
        ST_EMIT,
        ST_EXHAUST
    } t_back_state;

endpackage

### rtl/core/combination_enumerator.sv
// Top level of the lexicographic r-combination enumerator.
//
//  Port group    Direction  Handshake               Beat
//  in            sink       i_in_valid/o_in_ready   t_in_item: load or next request
//  out           source     o_out_valid/i_out_ready t_out_item: one slot or exhausted
//  apb           slave      psel/penable/pready     comb_size at 0x0, set_size at 0x4
//
// A load is written to the element store as the engine pops it from the two-entry
// queue. A next request steps through dequeue, carry search, index update and store
// read, then gives r results, one result a cycle while the output is not stalled; the
// first run after a restart skips the search. An exhausted answer follows the dequeue
// or the carry search. Reset is synchronous and active low; it clears control state
// and the chosen indices, while the element store keeps its contents. The result
// register holds a stalled beat and the queue lets the front keep taking requests.
module combination_enumerator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  comb_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output comb_pkg::t_out_item               o_out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [comb_pkg::PADDR_W-1:0]      paddr,
    input  logic [comb_pkg::PDATA_W-1:0]      pwdata,
    output logic [comb_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    logic [comb_pkg::R_W-1:0] r_comb_size;
    logic [comb_pkg::N_W-1:0] r_set_size;
    logic [comb_pkg::N_W-1:0] w_set_eff;
    logic                     w_cfg_wr;
    logic                     w_q_full;
    logic                     w_push;
    comb_pkg::t_cmd           w_push_cmd;
    logic                     w_pop;
    logic                     w_q_valid;
    comb_pkg::t_cmd           w_q_cmd;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        if (paddr[2] == comb_pkg::REG_COMB_SIZE) begin
            prdata = comb_pkg::PDATA_W'(r_comb_size);
        end else begin
            prdata = comb_pkg::PDATA_W'(r_set_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comb_size <= comb_pkg::COMB_SIZE_RESET;
            r_set_size  <= comb_pkg::SET_SIZE_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == comb_pkg::REG_COMB_SIZE) begin
                r_comb_size <= pwdata[comb_pkg::R_W-1:0];
            end else begin
                r_set_size <= pwdata[comb_pkg::N_W-1:0];
            end
        end
    end

    // A set larger than the store saturates to the store depth.
    assign w_set_eff = (int'(r_set_size) > comb_pkg::MAX_N) ? comb_pkg::N_W'(comb_pkg::MAX_N)
                                                            : r_set_size;

    comb_front u_front (
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_item),
        .i_comb_size (r_comb_size),
        .i_set_eff   (w_set_eff),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    comb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    comb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_cfg_wr),
        .i_comb_size (r_comb_size),
        .i_set_eff   (w_set_eff),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out_item)
    );

    a_exhausted_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.exhausted
        |-> o_out_item.last_of_run && (o_out_item.item_slot == '0))
        else $error("exhausted beat is not a lone final beat");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.exhausted
        |-> ({1'b0, o_out_item.item_slot} < {1'b0, r_comb_size}))
        else $error("result slot beyond combination size");

    a_last_on_final_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.exhausted && o_out_item.last_of_run
        |-> ({1'b0, o_out_item.item_slot} == {1'b0, r_comb_size} - 1'b1))
        else $error("last marker not on the final slot");

endmodule

### rtl/core/comb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module comb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/comb_front.sv
// Front end: accepts request beats and turns them into queued commands.
module comb_front (
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  comb_pkg::t_in_item                   i_item,
    input  logic [comb_pkg::R_W-1:0]             i_comb_size,
    input  logic [comb_pkg::N_W-1:0]             i_set_eff,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output comb_pkg::t_cmd                       o_cmd
);

    localparam int IdxW = comb_pkg::IDX_W;

    logic       w_accept;
    logic       w_keep;
    logic       w_empty_run;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && !i_q_full;

    // A combination that cannot exist is settled here and never reaches the search.
    assign w_empty_run = (i_comb_size == '0)
                      || (int'(i_comb_size) > comb_pkg::MAX_R)
                      || ({1'b0, i_comb_size} > i_set_eff);

    always_comb begin
        o_cmd.addr  = IdxW'(i_item.load_index);
        o_cmd.value = i_item.load_value;
        w_keep      = 1'b1;
        if (i_item.req_type == comb_pkg::REQ_LOAD) begin
            o_cmd.op = comb_pkg::OP_LOAD;
            w_keep   = int'(i_item.load_index) < comb_pkg::MAX_N;
        end else if (w_empty_run) begin
            o_cmd.op = comb_pkg::OP_EXHAUST;
        end else begin
            o_cmd.op = comb_pkg::OP_NEXT;
        end
    end

    assign o_push = w_accept && w_keep;

endmodule

### rtl/core/comb_queue.sv
// Short command queue between the front end and the enumeration engine.
module comb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  comb_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output comb_pkg::t_cmd o_cmd
);

    localparam int Depth = comb_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    comb_pkg::t_cmd  r_mem [Depth];
    logic [PtrW-1:0] r_wptr, n_wptr;
    logic [PtrW-1:0] r_rptr, n_rptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PtrW'(Depth - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PtrW'(Depth - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/comb_back.sv
// Enumeration engine: carry search over the chosen indices and result emission.
module comb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic [comb_pkg::R_W-1:0]      i_comb_size,
    input  logic [comb_pkg::N_W-1:0]      i_set_eff,
    input  logic                          i_q_valid,
    input  comb_pkg::t_cmd                i_q_cmd,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output comb_pkg::t_out_item           o_item
);

    localparam int IdxW  = comb_pkg::IDX_W;
    localparam int SlotW = comb_pkg::SLOT_IX_W;
    localparam int MaxR  = comb_pkg::MAX_R;

    comb_pkg::t_back_state r_state, n_state;

    logic [IdxW-1:0]        r_chosen [MaxR];
    logic [IdxW-1:0]        n_chosen [MaxR];
    logic                   r_started, n_started;
    logic [SlotW-1:0]       r_slot, n_slot;
    logic [SlotW-1:0]       r_pos;
    logic                   r_out_valid;
    comb_pkg::t_out_item    r_out;

    logic                   w_out_free;
    logic                   w_last;
    logic [SlotW-1:0]       w_slot_inc;
    logic                   w_can_adv [MaxR];
    logic [SlotW-1:0]       w_pos;
    logic                   w_found;
    logic                   w_ram_we;
    logic                   w_ram_re;
    logic [IdxW-1:0]        w_ram_raddr;
    logic [comb_pkg::VALUE_WIDTH-1:0] w_ram_rdata;
    logic                   w_load_out;
    comb_pkg::t_out_item    w_out;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_last     = ({1'b0, r_slot} == {1'b0, i_comb_size} - 1'b1);
    assign w_slot_inc = r_slot + 1'b1;

    // A slot can still advance while its index stays below n - r + slot.
    always_comb begin
        w_pos   = '0;
        w_found = 1'b0;
        for (int k = 0; k < MaxR; k++) begin
            w_can_adv[k] = (k < int'(i_comb_size))
                        && (int'(r_chosen[k]) + int'(i_comb_size) < int'(i_set_eff) + k);
            if (w_can_adv[k]) begin
                w_pos   = SlotW'(k);
                w_found = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            comb_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        comb_pkg::OP_LOAD:    n_state = comb_pkg::ST_IDLE;
                        comb_pkg::OP_EXHAUST: n_state = comb_pkg::ST_EXHAUST;
                        comb_pkg::OP_NEXT:    n_state = r_started ? comb_pkg::ST_SEARCH
                                                                  : comb_pkg::ST_ADVANCE;
                        default:              n_state = comb_pkg::ST_IDLE;
                    endcase
                end
            end
            comb_pkg::ST_SEARCH:  n_state = w_found ? comb_pkg::ST_ADVANCE
                                                    : comb_pkg::ST_EXHAUST;
            comb_pkg::ST_ADVANCE: n_state = comb_pkg::ST_PRIME;
            comb_pkg::ST_PRIME:   n_state = comb_pkg::ST_EMIT;
            comb_pkg::ST_EMIT: begin
                if (w_out_free && w_last) begin
                    n_state = comb_pkg::ST_IDLE;
                end
            end
            comb_pkg::ST_EXHAUST: begin
                if (w_out_free) begin
                    n_state = comb_pkg::ST_IDLE;
                end
            end
            default: n_state = comb_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb begin
        o_pop       = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_raddr = r_chosen[0];
        w_load_out  = 1'b0;
        w_out       = '0;
        n_slot      = r_slot;
        n_started   = r_started;
        for (int k = 0; k < MaxR; k++) begin
            n_chosen[k] = r_chosen[k];
        end
        case (r_state)
            comb_pkg::ST_IDLE: begin
                o_pop    = i_q_valid;
                w_ram_we = i_q_valid && (i_q_cmd.op == comb_pkg::OP_LOAD);
            end
            comb_pkg::ST_SEARCH: begin
            end
            comb_pkg::ST_ADVANCE: begin
                n_started = 1'b1;
                for (int k = 0; k < MaxR; k++) begin
                    if (!r_started) begin
                        n_chosen[k] = IdxW'(k);
                    end else if (k >= int'(r_pos)) begin
                        n_chosen[k] = r_chosen[r_pos] + 1'b1
                                    + (IdxW'(k) - IdxW'(r_pos));
                    end
                end
            end
            comb_pkg::ST_PRIME: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = r_chosen[0];
                n_slot      = '0;
            end
            comb_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    w_load_out        = 1'b1;
                    w_out.item_value  = w_ram_rdata;
                    w_out.item_slot   = comb_pkg::SLOT_W'(r_slot);
                    w_out.last_of_run = w_last;
                    w_out.exhausted   = 1'b0;
                    if (!w_last) begin
                        w_ram_re    = 1'b1;
                        w_ram_raddr = r_chosen[w_slot_inc];
                        n_slot      = w_slot_inc;
                    end
                end
            end
            comb_pkg::ST_EXHAUST: begin
                if (w_out_free) begin
                    w_load_out        = 1'b1;
                    w_out.last_of_run = 1'b1;
                    w_out.exhausted   = 1'b1;
                    n_started         = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    comb_ram #(
        .WIDTH (comb_pkg::VALUE_WIDTH),
        .DEPTH (comb_pkg::MAX_N)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_q_cmd.addr),
        .i_wdata (i_q_cmd.value),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= comb_pkg::ST_IDLE;
            r_started   <= 1'b0;
            r_slot      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MaxR; k++) begin
                r_chosen[k] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_started <= i_restart ? 1'b0 : n_started;
            r_slot    <= n_slot;
            if (r_state == comb_pkg::ST_SEARCH) begin
                r_pos <= w_pos;
            end
            for (int k = 0; k < MaxR; k++) begin
                r_chosen[k] <= n_chosen[k];
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_load_out) begin
            r_out <= w_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
